>>> hw/rtl/box_smoothing_filter_3x3_macros.svh
// Assertion macros shared by the box smoothing filter RTL.
`ifndef BOX_SMOOTHING_FILTER_3X3_MACROS_SVH
`define BOX_SMOOTHING_FILTER_3X3_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BSF3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BSF3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bsf3_pkg.sv
// Types and constants of the 3x3 box smoothing filter.
`timescale 1ns / 1ps

package bsf3_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_RESET = 8;

  localparam int SUM_W    = PIX_W + 4;
  localparam int RECIP_SH = SUM_W + 4;
  localparam int RECIP_W  = RECIP_SH - 2;
  localparam int RECIP6   = ((1 << RECIP_SH) + 5) / 6;
  localparam int RECIP9   = ((1 << RECIP_SH) + 8) / 9;

  typedef enum logic [1:0] {
    DIV_BY4,
    DIV_BY6,
    DIV_BY9
  } div_t;

endpackage

>>> hw/rtl/box_smoothing_filter_3x3.sv
// Top level of the 3x3 box smoothing filter.
// Takes a square image in raster order, one pixel per request, and returns the
// truncated mean of each pixel's in-image 3x3 neighborhood (divisor 4, 6 or 9).
// The two previous rows live in one single-port-read line store of MAX_SIZE
// entries, each entry holding the older and newer row pixel of one column.
// A request holds the block until done: a pixel with no result does a store
// read, then a window shift and store write; one with a result adds a sum
// stage and a reciprocal multiply stage, which waits while a result is stalled
// in the output register. A drain request for the last-but-one row starts at
// the sum stage; one for the last row reads the store first, plus a priming
// read at its first column. Drain requests (any request once the image is
// complete) emit the last N+1 results; the final one carries last.
// Results wait in an output register, so the next request is taken while a
// result is still stalled. Writing cfg_wr_data sets the side length, clamped
// to 2..MAX_SIZE, and restarts the image; write it only while idle.
`timescale 1ns / 1ps
`include "box_smoothing_filter_3x3_macros.svh"

module box_smoothing_filter_3x3 #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [bsf3_pkg::PIX_W-1:0]  in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bsf3_pkg::PIX_W-1:0]  out_smoothed,
  output logic                        out_last,
  input  logic                        cfg_wr_en,
  input  logic [bsf3_pkg::CFG_W-1:0]  cfg_wr_data
);

  import bsf3_pkg::*;

  localparam int ADDR_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SIZE_W  = $clog2(MAX_SIZE + 1);
  localparam int CMP_W   = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
  localparam int RESET_N = (CFG_RESET > MAX_SIZE) ? MAX_SIZE : CFG_RESET;
  localparam int PROD_W  = SUM_W + RECIP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_READ,
    S_SUM,
    S_DIV
  } state_t;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   n_r, n_nxt;
  logic [SIZE_W-1:0]   in_row_r, in_row_nxt;
  logic [SIZE_W-1:0]   in_col_r, in_col_nxt;
  logic [SIZE_W-1:0]   out_row_r, out_row_nxt;
  logic [SIZE_W-1:0]   out_col_r, out_col_nxt;
  logic [PIX_W-1:0]    win_r [3][3];
  logic [PIX_W-1:0]    win_nxt [3][3];
  logic [PIX_W-1:0]    px_r, px_nxt;
  logic                flush_r, flush_nxt;
  logic                k2_r, k2_nxt;
  logic                last_r, last_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  div_t                div_r, div_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]    out_smoothed_r, out_smoothed_nxt;
  logic                out_last_r, out_last_nxt;

  logic [2*PIX_W-1:0]  mem [MAX_SIZE];
  logic [2*PIX_W-1:0]  mem_rdata_r;
  logic                mem_re;
  logic                mem_we;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [2*PIX_W-1:0]  wr_data;

  logic [PROD_W-1:0]   prod;
  logic [PIX_W-1:0]    quot;

  always_comb begin
    logic [SIZE_W:0]   oc_inc;
    logic [SIZE_W:0]   or_inc;
    logic [SIZE_W:0]   ic_inc;
    logic [SIZE_W:0]   n_ext;
    logic [CMP_W-1:0]  cfg_ext;
    logic              in_done;
    logic              on_last_row;
    logic              got;
    logic [2:0]        row_en;
    logic [2:0]        col_en;
    logic [PIX_W-1:0]  elem;
    logic [SUM_W-1:0]  acc;

    state_nxt        = state_r;
    n_nxt            = n_r;
    in_row_nxt       = in_row_r;
    in_col_nxt       = in_col_r;
    out_row_nxt      = out_row_r;
    out_col_nxt      = out_col_r;
    win_nxt          = win_r;
    px_nxt           = px_r;
    flush_nxt        = flush_r;
    k2_nxt           = k2_r;
    last_nxt         = last_r;
    sum_nxt          = sum_r;
    div_nxt          = div_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_smoothed_nxt = out_smoothed_r;
    out_last_nxt     = out_last_r;
    mem_re           = 1'b0;
    mem_we           = 1'b0;
    rd_addr          = '0;
    wr_addr          = in_col_r[ADDR_W-1:0];
    wr_data          = {px_r, mem_rdata_r[2*PIX_W-1:PIX_W]};

    n_ext       = {1'b0, n_r};
    oc_inc      = {1'b0, out_col_r} + 1'b1;
    or_inc      = {1'b0, out_row_r} + 1'b1;
    ic_inc      = {1'b0, in_col_r} + 1'b1;
    in_done     = in_row_r >= n_r;
    on_last_row = or_inc >= n_ext;
    got         = 1'b0;
    row_en      = {!on_last_row, 1'b1, out_row_r != '0};
    col_en      = {oc_inc < n_ext, 1'b1, out_col_r != '0};
    acc         = '0;
    elem        = '0;
    cfg_ext     = CMP_W'(cfg_wr_data);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_op && !in_done) begin
            px_nxt    = in_pixel;
            flush_nxt = 1'b0;
            k2_nxt    = 1'b0;
            mem_re    = 1'b1;
            rd_addr   = in_col_r[ADDR_W-1:0];
            state_nxt = S_READ;
          end else if (in_done) begin
            flush_nxt = 1'b1;
            if (!on_last_row) begin
              k2_nxt    = 1'b1;
              state_nxt = S_SUM;
            end else begin
              k2_nxt = 1'b0;
              mem_re = 1'b1;
              if (out_col_r == '0) begin
                rd_addr   = '0;
                state_nxt = S_PRIME;
              end else begin
                rd_addr   = oc_inc[ADDR_W-1:0];
                state_nxt = S_READ;
              end
            end
          end
        end
      end
      S_PRIME: begin
        for (int r = 0; r < 2; r++) begin
          win_nxt[r][0] = win_r[r][1];
          win_nxt[r][1] = win_r[r][2];
        end
        win_nxt[0][2] = mem_rdata_r[PIX_W-1:0];
        win_nxt[1][2] = mem_rdata_r[2*PIX_W-1:PIX_W];
        mem_re        = 1'b1;
        rd_addr       = ADDR_W'(1);
        state_nxt     = S_READ;
      end
      S_READ: begin
        if (!flush_r) begin
          for (int r = 0; r < 3; r++) begin
            win_nxt[r][0] = win_r[r][1];
            win_nxt[r][1] = win_r[r][2];
          end
          win_nxt[0][2] = mem_rdata_r[PIX_W-1:0];
          win_nxt[1][2] = mem_rdata_r[2*PIX_W-1:PIX_W];
          win_nxt[2][2] = px_r;
          mem_we        = 1'b1;
          got = ((in_col_r == '0) && (in_row_r >= SIZE_W'(2))) ||
                ((in_row_r != '0) && (in_col_r != '0));
          if (ic_inc >= n_ext) begin
            in_col_nxt = '0;
            in_row_nxt = in_row_r + 1'b1;
          end else begin
            in_col_nxt = ic_inc[SIZE_W-1:0];
          end
          state_nxt = got ? S_SUM : S_IDLE;
        end else begin
          for (int r = 0; r < 2; r++) begin
            win_nxt[r][0] = win_r[r][1];
            win_nxt[r][1] = win_r[r][2];
          end
          win_nxt[0][2] = mem_rdata_r[PIX_W-1:0];
          win_nxt[1][2] = mem_rdata_r[2*PIX_W-1:PIX_W];
          state_nxt     = S_SUM;
        end
      end
      S_SUM: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if (k2_r) begin
              elem = (c == 2) ? '0 : win_r[r][(c + 1) % 3];
            end else begin
              elem = win_r[r][c];
            end
            if (row_en[r] && col_en[c]) begin
              acc = acc + SUM_W'(elem);
            end
          end
        end
        sum_nxt = acc;
        if (row_en[2] && row_en[0] && col_en[2] && col_en[0]) begin
          div_nxt = DIV_BY9;
        end else if ((row_en[2] && row_en[0]) || (col_en[2] && col_en[0])) begin
          div_nxt = DIV_BY6;
        end else begin
          div_nxt = DIV_BY4;
        end
        last_nxt = flush_r && on_last_row && (oc_inc >= n_ext);
        if (oc_inc >= n_ext) begin
          out_col_nxt = '0;
          out_row_nxt = or_inc[SIZE_W-1:0];
        end else begin
          out_col_nxt = oc_inc[SIZE_W-1:0];
        end
        if (last_nxt) begin
          in_row_nxt  = '0;
          in_col_nxt  = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
          for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
              win_nxt[r][c] = '0;
            end
          end
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_smoothed_nxt = quot;
          out_last_nxt     = last_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      if (cfg_ext < CMP_W'(2)) begin
        n_nxt = SIZE_W'(2);
      end else if (cfg_ext > CMP_W'(MAX_SIZE)) begin
        n_nxt = SIZE_W'(MAX_SIZE);
      end else begin
        n_nxt = cfg_ext[SIZE_W-1:0];
      end
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_nxt[r][c] = '0;
        end
      end
    end
  end

  always_comb begin
    prod = '0;
    quot = '0;
    case (div_r)
      DIV_BY6: begin
        prod = PROD_W'(sum_r) * PROD_W'(RECIP6);
        quot = PIX_W'(prod >> RECIP_SH);
      end
      DIV_BY9: begin
        prod = PROD_W'(sum_r) * PROD_W'(RECIP9);
        quot = PIX_W'(prod >> RECIP_SH);
      end
      default: begin
        quot = PIX_W'(sum_r >> 2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= SIZE_W'(RESET_N);
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      flush_r     <= 1'b0;
      k2_r        <= 1'b0;
      last_r      <= 1'b0;
      div_r       <= DIV_BY4;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      flush_r     <= flush_nxt;
      k2_r        <= k2_nxt;
      last_r      <= last_nxt;
      div_r       <= div_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      win_r       <= win_nxt;
    end
    px_r           <= px_nxt;
    sum_r          <= sum_nxt;
    out_smoothed_r <= out_smoothed_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_smoothed = out_smoothed_r;
  assign out_last     = out_last_r;

  `BSF3_ASSERT_NOW(a_store_write_on_push, mem_we, (state_r == S_READ) && !flush_r, "line store written outside a pixel request")
  `BSF3_ASSERT_NOW(a_out_behind_in, 1'b1, out_row_r <= in_row_r, "output row ran ahead of input row")
  `BSF3_ASSERT_NEXT(a_last_restarts, (state_r == S_SUM) && last_nxt, (in_row_r == '0) && (out_col_r == '0) && (out_row_r == '0), "positions not cleared after final result")

endmodule

>>> bench/bsf3_test_pkg.sv
// Request codes shared by the box smoothing filter testbench files.
`timescale 1ns / 1ps

package bsf3_test_pkg;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } req_op_t;

endpackage

>>> bench/box_smoothing_filter_3x3_checker.sv
// Checker for the 3x3 box smoothing filter: predicts each result and compares it.
`timescale 1ns / 1ps

module box_smoothing_filter_3x3_checker #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_op,
  input  logic [bsf3_pkg::PIX_W-1:0]  in_pixel,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [bsf3_pkg::PIX_W-1:0]  out_smoothed,
  input  logic                        out_last,
  input  logic                        cfg_wr_en,
  input  logic [bsf3_pkg::CFG_W-1:0]  cfg_wr_data,
  output int                          mismatches,
  output int                          pending,
  output int                          results_checked
);
  import bsf3_pkg::*;
  import bsf3_test_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic             last;
  } result_t;

  logic [CFG_W-1:0]      size_reg;
  logic [PIX_W-1:0]      older_row [MAX_SIZE];
  logic [PIX_W-1:0]      newer_row [MAX_SIZE];
  logic [8:0][PIX_W-1:0] win;
  int unsigned           in_r, in_c, out_r, out_c;
  result_t               smoothed_q [$];

  function automatic int unsigned side_len(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_SIZE) return MAX_SIZE;
    return 32'(v);
  endfunction

  function automatic logic [PIX_W-1:0] box_mean(input logic [8:0][PIX_W-1:0] w,
                                                input int unsigned k,
                                                input int unsigned orow,
                                                input int unsigned ocol,
                                                input int unsigned n);
    int unsigned sum, cnt, col;
    int          dr, dc;
    sum = 0;
    cnt = 0;
    for (dr = 0; dr < 3; dr++) begin
      if (dr == 0 && orow < 1) continue;
      if (dr == 2 && orow + 1 >= n) continue;
      for (dc = 0; dc < 3; dc++) begin
        col = k + dc - 1;
        if (dc == 0 && ocol < 1) continue;
        if (dc == 2 && ocol + 1 >= n) continue;
        if (col > 2) continue;
        sum += w[dr * 3 + col];
        cnt++;
      end
    end
    if (cnt == 0) return '0;
    return PIX_W'(sum / cnt);
  endfunction

  function automatic void clear_window();
    in_r  = 0;
    in_c  = 0;
    out_r = 0;
    out_c = 0;
    win   = '0;
  endfunction

  task automatic predict_request(input req_op_t op, input logic [PIX_W-1:0] pix);
    int unsigned           n, x, c;
    int                    j;
    logic                  got, fin;
    logic [PIX_W-1:0]      val;
    logic [8:0][PIX_W-1:0] tail;
    n   = side_len(size_reg);
    got = 1'b0;
    fin = 1'b0;
    val = '0;
    if (op == OP_PIXEL && in_r < n) begin
      x = in_c;
      if (x == 0 && in_r >= 2) begin
        val = box_mean(win, 2, out_r, out_c, n);
        got = 1'b1;
      end
      for (j = 0; j < 3; j++) begin
        win[j * 3]     = win[j * 3 + 1];
        win[j * 3 + 1] = win[j * 3 + 2];
      end
      win[2] = older_row[x];
      win[5] = newer_row[x];
      win[8] = pix;
      older_row[x] = newer_row[x];
      newer_row[x] = pix;
      if (!got && in_r >= 1 && x >= 1) begin
        val = box_mean(win, 1, out_r, out_c, n);
        got = 1'b1;
      end
      in_c++;
      if (in_c >= n) begin
        in_c = 0;
        in_r++;
      end
    end else if (in_r >= n) begin
      fin = (out_r == n - 1) && (out_c == n - 1);
      if (out_r + 1 < n) begin
        val = box_mean(win, 2, out_r, out_c, n);
      end else begin
        tail = '0;
        for (j = 0; j < 3; j++) begin
          c = out_c + j - 1;
          if (j == 0 && out_c < 1) continue;
          if (c >= n) continue;
          tail[j]     = older_row[c];
          tail[3 + j] = newer_row[c];
        end
        val = box_mean(tail, 1, out_r, out_c, n);
      end
      got = 1'b1;
    end
    if (got) begin
      out_c++;
      if (out_c >= n) begin
        out_c = 0;
        out_r++;
      end
      smoothed_q.push_back('{smoothed: val, last: fin});
    end
    if (fin) clear_window();
  endtask

  task automatic note_fault(input string what, input result_t want);
    if (mismatches < 10) begin
      $display("%t %s: expected smoothed=%0d last=%0d, got smoothed=%0d last=%0d",
               $time, what, want.smoothed, want.last, out_smoothed, out_last);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    int      i;
    if (!rst_n) begin
      size_reg = CFG_W'(CFG_RESET);
      clear_window();
      for (i = 0; i < MAX_SIZE; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      smoothed_q.delete();
      mismatches      = 0;
      results_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (smoothed_q.size() == 0) begin
          note_fault("unexpected result", '0);
        end else begin
          want = smoothed_q.pop_front();
          if (out_smoothed !== want.smoothed || out_last !== want.last) begin
            note_fault("result mismatch", want);
          end
        end
      end
      if (cfg_wr_en) begin
        size_reg = cfg_wr_data;
        clear_window();
      end else if (in_valid && !in_stall) begin
        predict_request(req_op_t'(in_op), in_pixel);
      end
    end
    pending <= smoothed_q.size();
  end

endmodule

>>> bench/box_smoothing_filter_3x3_test.sv
// Testbench top for the 3x3 box smoothing filter: stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module box_smoothing_filter_3x3_test;
  import bsf3_pkg::*;
  import bsf3_test_pkg::*;

  localparam int MAX_SIZE       = 1024;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE         = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 360;
  localparam int BIG_PUSHES     = 8;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_op       = OP_PIXEL;
  logic [PIX_W-1:0] in_pixel    = '0;
  logic             out_stall   = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_stall;
  logic             out_valid;
  logic [PIX_W-1:0] out_smoothed;
  logic             out_last;

  int mismatches, pending, results_checked;
  int items_sent   = 0;
  int images_sent  = 0;
  int sizes_used   = 0;
  int hold_req     = 0;
  int hold_ack     = 0;
  int quiet_cycles = 0;
  bit send_quiet   = 1'b0;

  always #5 clk = ~clk;

  box_smoothing_filter_3x3 #(
    .MAX_SIZE(MAX_SIZE)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_pixel    (in_pixel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_smoothed(out_smoothed),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  box_smoothing_filter_3x3_checker #(
    .MAX_SIZE(MAX_SIZE)
  ) watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_smoothed   (out_smoothed),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_checked(results_checked)
  );

  function automatic int side_of(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_SIZE) return MAX_SIZE;
    return int'(v);
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_req(input req_op_t op, input logic [PIX_W-1:0] pix, input bit counted);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall);
    if (counted) items_sent++;
  endtask

  task automatic noisy_push();
    if ($urandom_range(0, 99) < 8) send_req(OP_FLUSH, pick_pixel(), 1'b0);
    send_req(OP_PIXEL, pick_pixel(), 1'b1);
  endtask

  task automatic hold_off();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    hold_off();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sizes_used++;
  endtask

  task automatic send_image(input int n);
    int i;
    for (i = 0; i < n * n; i++) noisy_push();
    // drain: any request acts as a flush once the image is complete
    for (i = 0; i <= n; i++) begin
      if ($urandom_range(0, 99) < 30) send_req(OP_PIXEL, pick_pixel(), 1'b1);
      else send_req(OP_FLUSH, pick_pixel(), 1'b1);
    end
    images_sent++;
  endtask

  initial begin
    int run_left, hold_left, r;
    bit level;
    run_left  = 0;
    hold_left = 0;
    level     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 10) begin
            level    = 1'b0;
            run_left = $urandom_range(50, 150);
          end else if (r < 60) begin
            level    = 1'b0;
            run_left = $urandom_range(1, 8);
          end else if (r < 93) begin
            level    = 1'b1;
            run_left = $urandom_range(1, 3);
          end else begin
            level    = 1'b1;
            run_left = $urandom_range(20, 50);
          end
        end
        run_left--;
        out_stall <= level;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int               i, phase, n, kind, imgs, base;
    logic [PIX_W-1:0] px;
    logic [CFG_W-1:0] size_val;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // flush before any pixel: ignored
    send_req(OP_FLUSH, '1, 1'b0);
    // reset size, partial image: corners, edges and interior
    for (i = 0; i < 19; i++) begin
      if (i < 8) px = '1;
      else if (i < 16) px = (i % 2) ? '1 : '0;
      else px = (i % 2) ? '0 : '1;
      send_req(OP_PIXEL, px, 1'b1);
    end
    // size below range acts as the smallest image; push after completion drains
    write_size('0);
    repeat (4) send_req(OP_PIXEL, '1, 1'b1);
    send_req(OP_FLUSH, '0, 1'b1);
    send_req(OP_PIXEL, PIX_W'(8'h5a), 1'b1);
    send_req(OP_FLUSH, '0, 1'b1);

    // size above range acts as the largest; a few pixels of its first row
    write_size('1);
    for (i = 0; i < BIG_PUSHES; i++) send_req(OP_PIXEL, pick_pixel(), 1'b1);

    phase = 0;
    base  = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (phase == 0) begin
        size_val = CFG_W'(1);
      end else if (phase == 1) begin
        size_val = CFG_W'(6);
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 8) size_val = CFG_W'($urandom_range(0, 1));
        else if (kind < 30) size_val = CFG_W'(2);
        else if (kind < 94) size_val = CFG_W'($urandom_range(3, 9));
        else size_val = CFG_W'($urandom_range(10, 12));
      end
      write_size(size_val);
      n          = side_of(size_val);
      send_quiet = (phase == 1) || ($urandom_range(0, 3) == 0);
      // hold the output long enough for the block to back up
      if (phase == 1) hold_req++;
      imgs = $urandom_range(1, 3);
      for (i = 0; i < imgs; i++) begin
        if (items_sent - base >= RANDOM_ITEMS) break;
        if (phase > 1 && $urandom_range(0, 9) == 0) begin
          // drop the image part way; the next size write restarts it
          repeat ($urandom_range(1, n * n - 1)) noisy_push();
          break;
        end
        send_image(n);
        if ($urandom_range(0, 9) == 0) hold_off();
      end
      phase++;
    end

    hold_off();
    repeat (SETTLE) @(posedge clk);
    $display("run covered %0d requests, %0d complete images over %0d size writes",
             items_sent, images_sent, sizes_used);
    $display("%0d results compared, clamped sizes at both ends, %0d long output hold(s)",
             results_checked, hold_ack);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
